// ===== rtl/sparse_row_pattern_builder_macros.svh =====
// ----------------------------------------------------------------------------
// Sparse row pattern builder: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ROW_PATTERN_BUILDER_MACROS_SVH
`define SPARSE_ROW_PATTERN_BUILDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SRPB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SRPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/srpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse row pattern builder: package
// Widths, word kinds, state codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package srpb_pkg;

  // Row capacity and column index width
  localparam int MAX_ROW_ENTRIES = 32;
  localparam int COLUMN_BITS     = 20;

  // Derived widths: held count reaches the capacity itself
  localparam int CNT_W = $clog2(MAX_ROW_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ROW_ENTRIES);

  // Fixed port field widths
  localparam int OUT_COL_W   = 20;
  localparam int ROW_START_W = 27;
  localparam int ROW_COUNT_W = 6;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // What a queued word asks the back to do
  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_CLOSE,
    KIND_INSERT_CLOSE
  } kind_t;

  // Back end sequencer
  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    kind_t                  kind;
    logic [COLUMN_BITS-1:0] column;
  } q_item_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0]   column;
    logic                   column_valid;
    logic [ROW_START_W-1:0] row_start;
    logic [ROW_COUNT_W-1:0] row_count;
    logic                   overflow;
    logic                   last;
  } out_word_t;

endpackage

// ===== rtl/srpb_front.sv =====
// ----------------------------------------------------------------------------
// Sparse row pattern builder: front end
// Accepts input words, drops words that neither carry a column nor close the
// row, and hands the rest to the queue tagged with their kind.
// ----------------------------------------------------------------------------
module srpb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [srpb_pkg::COLUMN_BITS-1:0] in_column,
  input  logic                            in_has_column,
  input  logic                            in_end_of_row,
  output logic                            push_valid,
  input  logic                            push_ready,
  output srpb_pkg::q_item_t               push_item
);

  logic              stage_valid;
  srpb_pkg::q_item_t stage_item;
  logic              take;
  srpb_pkg::kind_t   kind_next;

  assign in_ready = !stage_valid || push_ready;
  assign take     = in_valid && in_ready;

  // Classify the incoming word
  always_comb begin
    if (in_has_column && in_end_of_row) begin
      kind_next = srpb_pkg::KIND_INSERT_CLOSE;
    end else if (in_end_of_row) begin
      kind_next = srpb_pkg::KIND_CLOSE;
    end else begin
      kind_next = srpb_pkg::KIND_INSERT;
    end
  end

  // Hold one word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= in_has_column || in_end_of_row;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_item.kind   <= kind_next;
      stage_item.column <= in_column;
    end
  end

  assign push_valid = stage_valid;
  assign push_item  = stage_item;

endmodule

// ===== rtl/srpb_queue.sv =====
// ----------------------------------------------------------------------------
// Sparse row pattern builder: word queue
// Short first-in first-out buffer that lets the front and back stall apart.
// ----------------------------------------------------------------------------
`include "sparse_row_pattern_builder_macros.svh"

module srpb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  srpb_pkg::q_item_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output srpb_pkg::q_item_t pop_item
);

  srpb_pkg::q_item_t                 slots [srpb_pkg::QUEUE_DEPTH];
  logic [srpb_pkg::QPTR_W-1:0]       wr_ptr;
  logic [srpb_pkg::QPTR_W-1:0]       rd_ptr;
  logic [srpb_pkg::QCNT_W-1:0]       count;
  logic                              push;
  logic                              pop;

  assign push_ready = count != srpb_pkg::QCNT_W'(srpb_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + srpb_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + srpb_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + srpb_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - srpb_pkg::QCNT_W'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `SRPB_ASSERT_SAME(a_queue_count_range, 1'b1, count <= srpb_pkg::QCNT_W'(srpb_pkg::QUEUE_DEPTH), "queue occupancy beyond depth")

endmodule

// ===== rtl/srpb_back.sv =====
// ----------------------------------------------------------------------------
// Sparse row pattern builder: back end
// Row of compare-insert cells that keeps the row's distinct columns sorted,
// and a sequencer that drains a closed row into the output register.
// ----------------------------------------------------------------------------
`include "sparse_row_pattern_builder_macros.svh"

module srpb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  srpb_pkg::q_item_t   pop_item,
  output logic                out_valid,
  input  logic                out_ready,
  output srpb_pkg::out_word_t out_word
);

  localparam int MAX = srpb_pkg::MAX_ROW_ENTRIES;
  localparam int CW  = srpb_pkg::COLUMN_BITS;

  logic [CW-1:0]                        cells [MAX];
  logic [MAX-1:0]                       lt;
  logic [MAX-1:0]                       eq;
  logic [srpb_pkg::CNT_W-1:0]           held_count;
  logic [srpb_pkg::ROW_START_W-1:0]     next_row_start;
  logic                                 dropped_flag;
  logic [srpb_pkg::IDX_W-1:0]           emit_idx;
  srpb_pkg::back_state_t                state;
  srpb_pkg::back_state_t                state_next;
  logic                                 pop;
  logic                                 want_ins;
  logic                                 want_close;
  logic                                 dup;
  logic                                 full;
  logic                                 ins_ok;
  logic                                 out_free;
  logic                                 emit_load;
  logic                                 emit_last;

  // Classify the word at the head of the queue
  assign want_ins   = pop_item.kind == srpb_pkg::KIND_INSERT
                   || pop_item.kind == srpb_pkg::KIND_INSERT_CLOSE;
  assign want_close = pop_item.kind == srpb_pkg::KIND_CLOSE
                   || pop_item.kind == srpb_pkg::KIND_INSERT_CLOSE;

  // Compare the candidate against every held cell
  always_comb begin
    for (int i = 0; i < MAX; i++) begin
      lt[i] = (srpb_pkg::CNT_W'(i) < held_count) && (cells[i] < pop_item.column);
      eq[i] = (srpb_pkg::CNT_W'(i) < held_count) && (cells[i] == pop_item.column);
    end
  end

  assign dup    = |eq;
  assign full   = held_count == srpb_pkg::CNT_W'(MAX);
  assign ins_ok = pop && want_ins && !dup && !full;

  // Each cell keeps its value, takes the candidate or takes its left neighbour
  for (genvar g = 0; g < MAX; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (ins_ok && !lt[g]) begin
          cells[g] <= pop_item.column;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (ins_ok && !lt[g]) begin
          cells[g] <= lt[g-1] ? pop_item.column : cells[g-1];
        end
      end
    end
  end

  // Output register frees when empty or being taken
  assign out_free  = !out_valid || out_ready;
  assign emit_last = (held_count == '0)
                  || (srpb_pkg::CNT_W'(emit_idx) + srpb_pkg::CNT_W'(1) == held_count);

  // Sequencer: take words, or drain a closed row
  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      srpb_pkg::ST_RUN: begin
        pop_ready = 1'b1;
        if (pop_valid && want_close) begin
          state_next = srpb_pkg::ST_EMIT;
        end
      end
      srpb_pkg::ST_EMIT: begin
        emit_load = out_free;
        if (out_free && emit_last) begin
          state_next = srpb_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = srpb_pkg::ST_RUN;
      end
    endcase
  end

  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srpb_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Row bookkeeping: count, overflow, start pointer and drain index
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      next_row_start <= srpb_pkg::ROW_START_W'(1);
      dropped_flag   <= 1'b0;
      emit_idx       <= '0;
    end else if (emit_load) begin
      if (emit_last) begin
        next_row_start <= next_row_start + srpb_pkg::ROW_START_W'(held_count);
        held_count     <= '0;
        dropped_flag   <= 1'b0;
        emit_idx       <= '0;
      end else begin
        emit_idx <= emit_idx + srpb_pkg::IDX_W'(1);
      end
    end else if (ins_ok) begin
      held_count <= held_count + srpb_pkg::CNT_W'(1);
    end else if (pop && want_ins && !dup && full) begin
      dropped_flag <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_word.column       <= (held_count == '0) ? '0
                                : srpb_pkg::OUT_COL_W'(cells[emit_idx]);
      out_word.column_valid <= held_count != '0;
      out_word.row_start    <= next_row_start;
      out_word.row_count    <= srpb_pkg::ROW_COUNT_W'(held_count);
      out_word.overflow     <= dropped_flag;
      out_word.last         <= emit_last;
    end
  end

  `SRPB_ASSERT_SAME(a_held_in_range, 1'b1, held_count <= srpb_pkg::CNT_W'(MAX), "held count beyond row capacity")
  `SRPB_ASSERT_SAME(a_no_pop_in_drain, state == srpb_pkg::ST_EMIT, !pop, "word taken while a row drains")
  `SRPB_ASSERT_NEXT(a_row_clears, emit_load && emit_last, held_count == '0 && !dropped_flag, "row state not cleared after final word")

endmodule

// ===== rtl/sparse_row_pattern_builder.sv =====
// ----------------------------------------------------------------------------
// Sparse row pattern builder: top level
// Collects candidate columns of one row into a sorted duplicate-free set and
// emits the row in ascending order with its start offset, count and overflow.
//
//   Channel  Dir  tdata (low bit up)                         tuser         tlast
//   s_axis   in   column[19:0], zero pad to 24               has_column    end_of_row
//   m_axis   out  out_column[19:0], row_start[46:20],        column_valid  last
//                 row_count[52:47], overflow[53], pad to 56
//
// A column word is taken straight into the compare-insert cells.
// A closing word starts a drain of the row through the output register, one
// word per distinct column or a single word for an empty row; the back takes
// no word during the drain while the front keeps filling a four-word queue.
// Input words reach the back through the front register and the queue.
// Reset is synchronous; the column store needs no clearing pass.
// ----------------------------------------------------------------------------
module sparse_row_pattern_builder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [srpb_pkg::IN_TDATA_W-1:0]     s_tdata,   // column[19:0], pad
  input  logic                                s_tuser,   // has_column
  input  logic                                s_tlast,   // end_of_row
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [srpb_pkg::OUT_TDATA_W-1:0]    m_tdata,   // out_column, row_start,
                                                         // row_count, overflow, pad
  output logic                                m_tuser,   // column_valid
  output logic                                m_tlast    // last
);

  logic                push_valid;
  logic                push_ready;
  srpb_pkg::q_item_t   push_item;
  logic                pop_valid;
  logic                pop_ready;
  srpb_pkg::q_item_t   pop_item;
  srpb_pkg::out_word_t out_word;

  srpb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_column     (s_tdata[srpb_pkg::COLUMN_BITS-1:0]),
    .in_has_column (s_tuser),
    .in_end_of_row (s_tlast),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  srpb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  srpb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  // Pack the result word onto the stream
  assign m_tdata = {2'b00, out_word.overflow, out_word.row_count,
                    out_word.row_start, out_word.column};
  assign m_tuser = out_word.column_valid;
  assign m_tlast = out_word.last;

endmodule
